FILE: rtl/rkd_pkg.sv
// rkd_pkg: shared types and constants for the remote key debouncer
// no dependencies
`timescale 1ns / 1ps

package rkd_pkg;

    localparam int FILTER_W = 7;
    localparam int COUNT_W  = 8;
    localparam int LONG_W   = 16;
    localparam int REPEAT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FILTER_W-1:0] FILTER_TIME_RST   = 7'd5;
    localparam logic [LONG_W-1:0]   LONG_TIME_RST     = 16'd100;
    localparam logic [REPEAT_W-1:0] REPEAT_PERIOD_RST = 8'd0;
    localparam logic [COUNT_W-1:0]  FILTER_COUNT_RST  =
        COUNT_W'(FILTER_TIME_RST / 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_TIME   = 2'd0,
        CFG_LONG_TIME     = 2'd1,
        CFG_REPEAT_PERIOD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [FILTER_W-1:0] filter_time;
        logic [LONG_W-1:0]   long_time;
        logic [REPEAT_W-1:0] repeat_period;
    } t_cfg;

    typedef struct packed {
        logic debounced_pressed;
        logic press_event;
        logic long_event;
        logic repeat_event;
        logic door_open_cmd;
        logic door_close_cmd;
        logic locked;
    } t_result;

endpackage

FILE: rtl/remote_key_debounce_toggle.sv
// remote_key_debounce_toggle: top level with input register, core and result register
// depends on rkd_pkg, rkd_cfg_regs, rkd_core
`timescale 1ns / 1ps
// path: an accepted input is held in the input register, then its result is loaded into the result register
// throughput: one item per cycle, limited only by output back-pressure
// input stalls when both registers hold an item and the result is not taken
// reset: synchronous active low; registers take their listed defaults, key state is
// released and the lock state is locked, filter counter starts at half the filter time

module remote_key_debounce_toggle (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_key_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_debounced_pressed,
    output logic                           o_press_event,
    output logic                           o_long_event,
    output logic                           o_repeat_event,
    output logic                           o_door_open_cmd,
    output logic                           o_door_close_cmd,
    output logic                           o_locked,
    input  logic                           i_cfg_we,
    input  logic [rkd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rkd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rkd_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_result r_result;

    logic r_in_valid;
    logic r_key_level;
    logic r_out_valid;
    logic out_load;
    logic in_take;

    assign out_load   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || out_load;
    assign in_take    = i_in_valid && o_in_ready;

    rkd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rkd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (out_load),
        .i_key_level (r_key_level),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key_level <= i_key_level;
        end
        if (out_load) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_debounced_pressed = r_result.debounced_pressed;
    assign o_press_event       = r_result.press_event;
    assign o_long_event        = r_result.long_event;
    assign o_repeat_event      = r_result.repeat_event;
    assign o_door_open_cmd     = r_result.door_open_cmd;
    assign o_door_close_cmd    = r_result.door_close_cmd;
    assign o_locked            = r_result.locked;

endmodule

FILE: rtl/rkd_cfg_regs.sv
// rkd_cfg_regs: configuration register bank with write decoder
// depends on rkd_pkg
`timescale 1ns / 1ps

module rkd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rkd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rkd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rkd_pkg::t_cfg                  o_cfg
);
    import rkd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FILTER_TIME:   n_cfg.filter_time   = i_cfg_data[FILTER_W-1:0];
                CFG_LONG_TIME:     n_cfg.long_time     = i_cfg_data[LONG_W-1:0];
                CFG_REPEAT_PERIOD: n_cfg.repeat_period = i_cfg_data[REPEAT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_time   <= FILTER_TIME_RST;
            r_cfg.long_time     <= LONG_TIME_RST;
            r_cfg.repeat_period <= REPEAT_PERIOD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/rkd_core.sv
// rkd_core: debounce, hold, repeat and lock state with per-tick update logic
// depends on rkd_pkg
`timescale 1ns / 1ps

module rkd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_key_level,
    input  rkd_pkg::t_cfg    i_cfg,
    output rkd_pkg::t_result o_result
);
    import rkd_pkg::*;

    logic [COUNT_W-1:0]  r_filter_count, n_filter_count;
    logic                r_pressed, n_pressed;
    logic [LONG_W-1:0]   r_hold_count, n_hold_count;
    logic [REPEAT_W-1:0] r_repeat_count, n_repeat_count;
    logic                r_lock, n_lock;

    logic [COUNT_W-1:0]  filter_low;
    logic [COUNT_W-1:0]  filter_top;
    logic [REPEAT_W-1:0] repeat_inc;
    t_result             result;

    assign filter_low = {1'b0, i_cfg.filter_time};
    assign filter_top = {i_cfg.filter_time, 1'b0};
    assign repeat_inc = r_repeat_count + REPEAT_W'(1);

    always_comb begin
        n_filter_count = r_filter_count;
        n_pressed      = r_pressed;
        n_hold_count   = r_hold_count;
        n_repeat_count = r_repeat_count;
        n_lock         = r_lock;
        result         = '0;
        if (!i_key_level) begin
            if (r_filter_count < filter_low) begin
                n_filter_count = filter_low;
            end else if (r_filter_count < filter_top) begin
                n_filter_count = r_filter_count + COUNT_W'(1);
            end else begin
                if (!r_pressed) begin
                    n_pressed          = 1'b1;
                    result.press_event = 1'b1;
                end
                if (i_cfg.long_time != '0) begin
                    if (r_hold_count < i_cfg.long_time) begin
                        n_hold_count = r_hold_count + LONG_W'(1);
                        if (n_hold_count == i_cfg.long_time) begin
                            result.long_event = 1'b1;
                        end
                    end else if (i_cfg.repeat_period != '0) begin
                        if (repeat_inc >= i_cfg.repeat_period) begin
                            n_repeat_count      = '0;
                            result.repeat_event = 1'b1;
                        end else begin
                            n_repeat_count = repeat_inc;
                        end
                    end
                end
            end
        end else begin
            if (r_filter_count > filter_low) begin
                n_filter_count = filter_low;
            end else if (r_filter_count != '0) begin
                n_filter_count = r_filter_count - COUNT_W'(1);
            end else if (r_pressed) begin
                n_pressed = 1'b0;
                if (r_hold_count < i_cfg.long_time) begin
                    n_lock = ~r_lock;
                    if (r_lock) begin
                        result.door_open_cmd = 1'b1;
                    end else begin
                        result.door_close_cmd = 1'b1;
                    end
                end
                n_hold_count = '0;
            end
            n_repeat_count = '0;
        end
        result.debounced_pressed = n_pressed;
        result.locked            = n_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_count <= FILTER_COUNT_RST;
            r_pressed      <= 1'b0;
            r_hold_count   <= '0;
            r_repeat_count <= '0;
            r_lock         <= 1'b1;
        end else if (i_step) begin
            r_filter_count <= n_filter_count;
            r_pressed      <= n_pressed;
            r_hold_count   <= n_hold_count;
            r_repeat_count <= n_repeat_count;
            r_lock         <= n_lock;
        end
    end

    assign o_result = result;

    // door commands only on a debounced release
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (result.door_open_cmd || result.door_close_cmd))
            |=> (!r_pressed && $past(r_pressed)))
        else $error("door command without a debounced release");

    // open means now unlocked, close means now locked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && result.door_open_cmd) |=> !r_lock)
        else $error("door open without unlock");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && result.door_close_cmd) |=> r_lock)
        else $error("door close without lock");

    // long and repeat pulses only while held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (result.long_event || result.repeat_event)) |=> r_pressed)
        else $error("long or repeat pulse while released");

    // lock state changes only by a stepped item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_lock))
        else $error("lock state changed without an item");

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking bench for remote_key_debounce_toggle, random and directed key ticks
// with a built-in debounce/long-press/lock predictor and a scoreboard of expected results
// depends on rkd_pkg and the remote_key_debounce_toggle rtl
`timescale 1ns / 1ps

module tb_top;

    import rkd_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  key_level = 1'b1;
    logic                  out_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FILTER_TIME;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wire     in_ready;
    wire     out_valid;
    wire     pressed_o, press_ev_o, long_ev_o, repeat_ev_o, open_o, close_o, locked_o;
    t_result observed;

    assign observed = {pressed_o, press_ev_o, long_ev_o, repeat_ev_o, open_o, close_o, locked_o};

    remote_key_debounce_toggle u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_key_level         (key_level),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_debounced_pressed (pressed_o),
        .o_press_event       (press_ev_o),
        .o_long_event        (long_ev_o),
        .o_repeat_event      (repeat_ev_o),
        .o_door_open_cmd     (open_o),
        .o_door_close_cmd    (close_o),
        .o_locked            (locked_o),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    // predictor configuration and state
    logic [FILTER_W-1:0] cfg_filter = FILTER_TIME_RST;
    logic [LONG_W-1:0]   cfg_long   = LONG_TIME_RST;
    logic [REPEAT_W-1:0] cfg_repeat = REPEAT_PERIOD_RST;
    logic [COUNT_W-1:0]  flt_cnt    = FILTER_COUNT_RST;
    logic                key_down   = 1'b0;
    logic [LONG_W-1:0]   hold_cnt   = '0;
    logic [REPEAT_W-1:0] rpt_cnt    = '0;
    logic                door_locked = 1'b1;

    logic    pending_levels[$];
    t_result expected_results[$];
    int      items_queued = 0;
    int      results_seen = 0;
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    logic    hold_armed = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_left = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_result debounce_tick(input logic level);
        t_result            r;
        logic [COUNT_W-1:0] filt;
        logic [COUNT_W-1:0] upper;
        r     = '0;
        filt  = COUNT_W'(cfg_filter);
        upper = filt << 1;
        if (level == 1'b0) begin
            if (flt_cnt < filt) begin
                flt_cnt = filt;
            end else if (flt_cnt < upper) begin
                flt_cnt = flt_cnt + 8'd1;
            end else begin
                if (!key_down) begin
                    key_down      = 1'b1;
                    r.press_event = 1'b1;
                end
                if (cfg_long != '0) begin
                    if (hold_cnt < cfg_long) begin
                        hold_cnt = hold_cnt + 16'd1;
                        if (hold_cnt == cfg_long) r.long_event = 1'b1;
                    end else if (cfg_repeat != '0) begin
                        rpt_cnt = rpt_cnt + 8'd1;
                        if (rpt_cnt >= cfg_repeat) begin
                            rpt_cnt        = '0;
                            r.repeat_event = 1'b1;
                        end
                    end
                end
            end
        end else begin
            if (flt_cnt > filt) begin
                flt_cnt = filt;
            end else if (flt_cnt != '0) begin
                flt_cnt = flt_cnt - 8'd1;
            end else if (key_down) begin
                key_down = 1'b0;
                // short release toggles the lock
                if (hold_cnt < cfg_long) begin
                    if (door_locked) begin
                        door_locked     = 1'b0;
                        r.door_open_cmd = 1'b1;
                    end else begin
                        door_locked      = 1'b1;
                        r.door_close_cmd = 1'b1;
                    end
                end
                hold_cnt = '0;
            end
            rpt_cnt = '0;
        end
        r.debounced_pressed = key_down;
        r.locked            = door_locked;
        return r;
    endfunction

    task automatic check_field(input string field, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, field, exp_v, act_v);
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(debounce_tick(key_level));
            end
            if (!in_valid || in_ready) begin
                if (pending_levels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid  <= 1'b1;
                    key_level <= pending_levels.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no item pending, actual %b", $time, observed);
                end else begin
                    want = expected_results.pop_front();
                    check_field("debounced_pressed", want.debounced_pressed, observed.debounced_pressed);
                    check_field("press_event", want.press_event, observed.press_event);
                    check_field("long_event", want.long_event, observed.long_event);
                    check_field("repeat_event", want.repeat_event, observed.repeat_event);
                    check_field("door_open_cmd", want.door_open_cmd, observed.door_open_cmd);
                    check_field("door_close_cmd", want.door_close_cmd, observed.door_close_cmd);
                    check_field("locked", want.locked, observed.locked);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 160;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_level(input logic level);
        pending_levels.push_back(level);
        items_queued++;
    endtask

    task automatic push_run(input logic level, input int n);
        repeat (n) push_level(level);
    endtask

    task automatic wait_idle();
        while (results_seen != items_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [FILTER_W-1:0] f, input logic [LONG_W-1:0] l,
                              input logic [REPEAT_W-1:0] p);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FILTER_TIME;
        cfg_data  <= CFG_DATA_W'(f);
        @(posedge clk);
        cfg_index <= CFG_LONG_TIME;
        cfg_data  <= l;
        @(posedge clk);
        cfg_index <= CFG_REPEAT_PERIOD;
        cfg_data  <= CFG_DATA_W'(p);
        @(posedge clk);
        cfg_we     <= 1'b0;
        cfg_filter = f;
        cfg_long   = l;
        cfg_repeat = p;
    endtask

    // press/release sequences with bounce, plus some raw noise
    task automatic gen_presses(input int total, input int cap);
        int made;
        int k;
        int extra;
        int low_len;
        int high_len;
        made  = 0;
        extra = int'(cfg_long) + 3 * int'(cfg_repeat) + 4;
        if (extra > cap) extra = cap;
        while (made < total) begin
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(1, 8);
                repeat (k) push_level(1'($urandom_range(0, 1)));
                made += k;
            end else begin
                k = $urandom_range(0, 3);
                repeat (k) push_level(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 4) == 0)
                    low_len = $urandom_range(1, 2 * int'(cfg_filter) + 2);
                else
                    low_len = 2 * int'(cfg_filter) + 1 + $urandom_range(0, extra);
                push_run(1'b0, low_len);
                high_len = $urandom_range(1, 2 * int'(cfg_filter) + 4);
                push_run(1'b1, high_len);
                made += k + low_len + high_len;
            end
        end
    endtask

    initial begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 75, 0, 24};
        recv_pct = '{0, 0, 75, 24};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // short press with the reset settings unlocks
        push_run(1'b0, 8);
        push_run(1'b1, 12);

        // long press with repeats, then a short press
        set_config(7'd1, 16'd3, 8'd2);
        push_run(1'b0, 7);
        push_run(1'b1, 4);
        push_run(1'b0, 3);
        push_run(1'b1, 3);

        // long detection off: no toggle
        set_config(7'd1, 16'd0, 8'd2);
        push_run(1'b0, 4);
        push_run(1'b1, 3);

        // zero filter
        set_config(7'd0, 16'd3, 8'd2);
        push_level(1'b0);
        push_level(1'b1);
        push_run(1'b0, 5);
        push_level(1'b1);

        // long time lowered below the hold count, then repeat period lowered
        set_config(7'd1, 16'd10, 8'd3);
        push_run(1'b0, 6);
        set_config(7'd1, 16'd2, 8'd3);
        push_run(1'b0, 5);
        set_config(7'd1, 16'd2, 8'd1);
        push_run(1'b0, 2);
        push_run(1'b1, 4);

        for (int ph = 0; ph < 4; ph++) begin
            set_config(7'($urandom_range(1, 6)), 16'($urandom_range(0, 25)),
                       8'($urandom_range(0, 5)));
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            gen_presses(250, 60);
        end

        // receiver holds off while the sender keeps offering
        set_config(7'($urandom_range(1, 4)), 16'($urandom_range(1, 12)),
                   8'($urandom_range(1, 4)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_presses(100, 30);
        hold_armed = 1'b1;

        set_config(7'd127, 16'hFFFF, 8'hFF);
        send_idle_pct = 24;
        recv_idle_pct = 24;
        gen_presses(400, 40);

        set_config(7'd2, 16'd5, 8'hFF);
        gen_presses(450, 600);

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/rkd_pkg.sv
rtl/rkd_cfg_regs.sv
rtl/rkd_core.sv
rtl/remote_key_debounce_toggle.sv
test/tb_top.sv
